### hdl/pfco_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfco_pkg
// Shared types, constants and state encoding for the prime factor count
// ordering block.
// ----------------------------------------------------------------------------
package pfco_pkg;

    localparam int NUM_W = 21;
    localparam logic [NUM_W-1:0] UPPER_BOUND_RESET = 21'd2000000;

    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic             func;
        logic [NUM_W-1:0] position;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0] value;
        logic             status;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SIEVE_RD,
        ST_SIEVE_CHK,
        ST_MULT_RD,
        ST_MULT_WR,
        ST_SIEVE_POW,
        ST_HIST_CLR,
        ST_HIST,
        ST_PREFIX,
        ST_PLACE,
        ST_QUERY,
        ST_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        t_state state;
        logic   load;
        logic   build;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic clear_done;
        logic n_done;
        logic is_prime;
        logic mult_done;
        logic pow_next;
        logic c_last;
        logic hist_done;
        logic prefix_done;
        logic place_done;
    } t_stat;

endpackage

### hdl/prime_factor_count_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_factor_count_order
// Big-omega sieve with counting-sort ordering and positional queries.
// Query: IDLE, QUERY and DONE states, then a registered strobe; none is taken while busy.
// Build with bound B: a clear pass over 0..B, a sieve that tests each number,
// bumps the count of each multiple and steps prime powers, then histogram,
// prefix and placement passes and a finishing state; single RAM ports.
// Reset clears control and the built flag; memories are written by each build.
// The receiver cannot stall: each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module prime_factor_count_order #(
    parameter int TABLE_DEPTH = 2097152,
    parameter int MAX_COUNT   = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  pfco_pkg::t_in              i_in,
    output logic                       o_strobe,
    output pfco_pkg::t_out             o_out,
    input  logic                       i_cfg_we,
    input  logic [pfco_pkg::NUM_W-1:0] i_cfg_data
);
    logic [pfco_pkg::NUM_W-1:0] r_upper_bound, r_position;
    pfco_pkg::t_cmd  cmd;
    pfco_pkg::t_stat stat;

    // hold the bound register and the query position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_bound <= pfco_pkg::UPPER_BOUND_RESET;
        end else if (i_cfg_we) begin
            r_upper_bound <= i_cfg_data;
        end
        if (start && !busy) begin
            r_position <= i_in.position;
        end
    end

    pfco_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_in.func),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy), .o_strobe(o_strobe));

    pfco_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_COUNT(MAX_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_upper_bound(r_upper_bound), .i_position(r_position),
        .o_stat(stat), .o_result(o_out));
endmodule

### hdl/pfco_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfco_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/pfco_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfco_datapath
// Counters, address generation and memories for sieve, histogram, prefix
// starts, placement and queries.
// ----------------------------------------------------------------------------
module pfco_datapath #(
    parameter int TABLE_DEPTH = 2097152,
    parameter int MAX_COUNT   = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfco_pkg::t_cmd             i_cmd,
    input  logic [pfco_pkg::NUM_W-1:0] i_upper_bound,
    input  logic [pfco_pkg::NUM_W-1:0] i_position,
    output pfco_pkg::t_stat            o_stat,
    output pfco_pkg::t_out             o_result
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(MAX_COUNT);
    localparam int NW = pfco_pkg::NUM_W;
    // counters carry a spare bit so they can pass the bound
    localparam int XW = (AW > NW ? AW : NW) + 1;
    localparam logic [XW-1:0] TOP = XW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_COUNT - 1);
    // per-number phases of the histogram and placement passes
    localparam logic [1:0] PH_ADDR  = 2'd0;
    localparam logic [1:0] PH_READ  = 2'd1;
    localparam logic [1:0] PH_WRITE = 2'd2;

    logic [XW-1:0] r_bound, r_n, r_pw, r_m;
    logic [CW-1:0] r_c;
    logic [AW:0]   r_sum;
    logic [CW-1:0] r_cnt_q;
    logic [1:0]    r_ph;
    logic          r_built;
    logic [XW-1:0] r_built_bound;
    pfco_pkg::t_out r_res;

    // factor count memory
    logic          fc_we;
    logic [AW-1:0] fc_addr;
    logic [CW-1:0] fc_wdata, fc_rdata;
    // ordered numbers memory
    logic          on_we;
    logic [AW-1:0] on_addr;
    logic [NW-1:0] on_wdata, on_rdata;
    // bucket start memory
    logic          bs_we;
    logic [CW-1:0] bs_addr;
    logic [AW:0]   bs_wdata, bs_rdata;

    pfco_ram #(.WIDTH(CW), .DEPTH(TABLE_DEPTH)) u_fc (
        .i_clk(i_clk), .i_we(fc_we), .i_addr(fc_addr),
        .i_wdata(fc_wdata), .o_rdata(fc_rdata));
    pfco_ram #(.WIDTH(NW), .DEPTH(TABLE_DEPTH)) u_on (
        .i_clk(i_clk), .i_we(on_we), .i_addr(on_addr),
        .i_wdata(on_wdata), .o_rdata(on_rdata));
    pfco_ram #(.WIDTH(AW + 1), .DEPTH(MAX_COUNT)) u_bs (
        .i_clk(i_clk), .i_we(bs_we), .i_addr(bs_addr),
        .i_wdata(bs_wdata), .o_rdata(bs_rdata));

    logic [2*XW-1:0] pw_prod;
    logic [XW-1:0]   bound_x;

    assign bound_x = (XW'(i_upper_bound) > TOP) ? TOP : XW'(i_upper_bound);
    // compare pw*n against the bound instead of dividing
    assign pw_prod = r_pw * r_n;

    // memory port control
    always_comb begin
        fc_we    = 1'b0;
        fc_addr  = r_n[AW-1:0];
        fc_wdata = '0;
        on_we    = 1'b0;
        on_addr  = r_n[AW-1:0];
        on_wdata = r_n[NW-1:0];
        bs_we    = 1'b0;
        bs_addr  = r_c;
        bs_wdata = '0;
        case (i_cmd.state)
            pfco_pkg::ST_CLEAR: begin
                fc_we = 1'b1;
            end
            pfco_pkg::ST_MULT_RD: begin
                fc_addr = r_m[AW-1:0];
            end
            pfco_pkg::ST_MULT_WR: begin
                fc_addr  = r_m[AW-1:0];
                fc_we    = 1'b1;
                fc_wdata = (fc_rdata < CMAX) ? fc_rdata + 1'b1 : fc_rdata;
            end
            pfco_pkg::ST_HIST_CLR: begin
                bs_we = 1'b1;
            end
            pfco_pkg::ST_HIST, pfco_pkg::ST_PLACE: begin
                // read count, then its bucket, then bump the bucket
                if (r_ph == PH_READ) begin
                    bs_addr = fc_rdata;
                end else if (r_ph == PH_WRITE) begin
                    bs_addr  = r_cnt_q;
                    bs_we    = 1'b1;
                    bs_wdata = bs_rdata + 1'b1;
                    if (i_cmd.state == pfco_pkg::ST_PLACE) begin
                        on_we   = 1'b1;
                        on_addr = bs_rdata[AW-1:0];
                    end
                end
            end
            pfco_pkg::ST_PREFIX: begin
                if (r_ph == PH_READ) begin
                    bs_we    = 1'b1;
                    bs_wdata = r_sum;
                end
            end
            pfco_pkg::ST_QUERY: begin
                on_addr = AW'(i_position);
            end
            default: begin
            end
        endcase
    end

    // status towards the controller
    always_comb begin
        o_stat.clear_done  = (r_n == r_bound);
        o_stat.n_done      = (r_n > r_bound);
        o_stat.is_prime    = (fc_rdata == '0);
        o_stat.mult_done   = (r_m > r_bound);
        o_stat.pow_next    = (pw_prod <= (2*XW)'(r_bound));
        o_stat.c_last      = (r_c == CMAX);
        o_stat.hist_done   = (r_n == r_bound) && (r_ph == PH_WRITE);
        o_stat.prefix_done = (r_c == CMAX) && (r_ph == PH_READ);
        o_stat.place_done  = (r_n == r_bound) && (r_ph == PH_WRITE);
    end

    // advance counters per state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound       <= '0;
            r_n           <= '0;
            r_pw          <= '0;
            r_m           <= '0;
            r_c           <= '0;
            r_sum         <= '0;
            r_cnt_q       <= '0;
            r_built       <= 1'b0;
            r_built_bound <= '0;
            r_ph          <= PH_ADDR;
            r_res         <= '0;
        end else begin
            case (i_cmd.state)
                pfco_pkg::ST_IDLE: begin
                    if (i_cmd.load) begin
                        r_bound <= bound_x;
                        r_n     <= '0;
                    end
                    r_ph <= PH_ADDR;
                end
                pfco_pkg::ST_CLEAR: begin
                    r_n <= o_stat.clear_done ? XW'(2) : r_n + 1'b1;
                end
                pfco_pkg::ST_SIEVE_RD: begin
                    r_c <= '0;
                end
                pfco_pkg::ST_SIEVE_CHK: begin
                    if (o_stat.is_prime) begin
                        r_pw <= r_n;
                        r_m  <= r_n;
                    end else begin
                        r_n <= r_n + 1'b1;
                    end
                end
                pfco_pkg::ST_MULT_WR: begin
                    r_m <= r_m + r_pw;
                end
                pfco_pkg::ST_SIEVE_POW: begin
                    if (o_stat.pow_next) begin
                        r_pw <= pw_prod[XW-1:0];
                        r_m  <= pw_prod[XW-1:0];
                    end else begin
                        r_n <= r_n + 1'b1;
                    end
                end
                pfco_pkg::ST_HIST_CLR: begin
                    r_c  <= o_stat.c_last ? '0 : r_c + 1'b1;
                    r_n  <= '0;
                    r_ph <= PH_ADDR;
                end
                pfco_pkg::ST_HIST, pfco_pkg::ST_PLACE: begin
                    if (r_ph == PH_WRITE) begin
                        r_ph <= PH_ADDR;
                        if (r_n == r_bound) begin
                            r_n   <= '0;
                            r_c   <= '0;
                            r_sum <= '0;
                        end else begin
                            r_n <= r_n + 1'b1;
                        end
                    end else begin
                        if (r_ph == PH_READ) begin
                            r_cnt_q <= fc_rdata;
                        end
                        r_ph <= r_ph + 1'b1;
                    end
                end
                pfco_pkg::ST_PREFIX: begin
                    if (r_ph == PH_READ) begin
                        r_sum <= r_sum + bs_rdata;
                        r_c   <= o_stat.c_last ? '0 : r_c + 1'b1;
                        r_ph  <= PH_ADDR;
                        r_n   <= '0;
                    end else begin
                        r_ph <= PH_READ;
                    end
                end
                pfco_pkg::ST_DONE: begin
                    if (i_cmd.build) begin
                        r_built       <= 1'b1;
                        r_built_bound <= r_bound;
                        r_res         <= '0;
                    end else if (!r_built || XW'(i_position) > r_built_bound) begin
                        r_res <= '{value: '0, status: pfco_pkg::STATUS_ERR};
                    end else begin
                        r_res <= '{value: on_rdata, status: pfco_pkg::STATUS_OK};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = r_res;
endmodule

### hdl/pfco_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfco_ctrl
// Sequencer for build passes and queries.
// ----------------------------------------------------------------------------
module pfco_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_func,
    input  pfco_pkg::t_stat i_stat,
    output pfco_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_strobe
);
    pfco_pkg::t_state r_state, n_state;
    logic r_build, n_build, r_strobe, n_strobe;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfco_pkg::ST_IDLE;
            r_build  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_build  <= n_build;
            r_strobe <= n_strobe;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_build     = r_build;
        n_strobe    = 1'b0;
        o_cmd.state = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.build = 1'b0;
        case (r_state)
            pfco_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_build = (i_func == pfco_pkg::FUNC_BUILD);
                    n_state = (i_func == pfco_pkg::FUNC_BUILD) ?
                              pfco_pkg::ST_CLEAR : pfco_pkg::ST_QUERY;
                end
            end
            pfco_pkg::ST_CLEAR: begin
                if (i_stat.clear_done) n_state = pfco_pkg::ST_SIEVE_RD;
            end
            // read count of n, then test it
            pfco_pkg::ST_SIEVE_RD: begin
                n_state = i_stat.n_done ? pfco_pkg::ST_HIST_CLR : pfco_pkg::ST_SIEVE_CHK;
            end
            pfco_pkg::ST_SIEVE_CHK: begin
                n_state = i_stat.is_prime ? pfco_pkg::ST_MULT_RD : pfco_pkg::ST_SIEVE_RD;
            end
            // walk multiples of the current power: read, then write
            pfco_pkg::ST_MULT_RD: begin
                n_state = i_stat.mult_done ? pfco_pkg::ST_SIEVE_POW : pfco_pkg::ST_MULT_WR;
            end
            pfco_pkg::ST_MULT_WR: begin
                n_state = pfco_pkg::ST_MULT_RD;
            end
            pfco_pkg::ST_SIEVE_POW: begin
                n_state = i_stat.pow_next ? pfco_pkg::ST_MULT_RD : pfco_pkg::ST_SIEVE_RD;
            end
            pfco_pkg::ST_HIST_CLR: begin
                if (i_stat.c_last) n_state = pfco_pkg::ST_HIST;
            end
            pfco_pkg::ST_HIST: begin
                if (i_stat.hist_done) n_state = pfco_pkg::ST_PREFIX;
            end
            pfco_pkg::ST_PREFIX: begin
                if (i_stat.prefix_done) n_state = pfco_pkg::ST_PLACE;
            end
            pfco_pkg::ST_PLACE: begin
                if (i_stat.place_done) n_state = pfco_pkg::ST_DONE;
            end
            pfco_pkg::ST_QUERY: begin
                n_state = pfco_pkg::ST_DONE;
            end
            pfco_pkg::ST_DONE: begin
                o_cmd.build = r_build;
                n_strobe = 1'b1;
                n_state  = pfco_pkg::ST_IDLE;
            end
            default: begin
                n_state = pfco_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != pfco_pkg::ST_IDLE);
    assign o_strobe = r_strobe;

    // a result strobe follows only a finished transaction
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == pfco_pkg::ST_DONE)) else $error("stray strobe");
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfco_pkg::ST_DONE |=> r_state == pfco_pkg::ST_IDLE)
        else $error("done not followed by idle");
    a_query_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfco_pkg::ST_QUERY |=> r_state == pfco_pkg::ST_DONE)
        else $error("query overran");
endmodule
